// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a property holds on every clock edge out of reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Check that a condition never occurs out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== hdl/pbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types, register indexes and divide helpers of the pixel converter.
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int MAX_ROW_BYTES = 512;

    localparam logic [2:0] REG_SOURCE_FORMAT = 3'd0;
    localparam logic [2:0] REG_GLOBAL_ALPHA  = 3'd1;
    localparam logic [2:0] REG_FG_COLOUR     = 3'd2;
    localparam logic [2:0] REG_BG_COLOUR     = 3'd3;
    localparam logic [2:0] REG_DRAW_WIDTH    = 3'd4;
    localparam logic [2:0] REG_ROW_BYTES     = 3'd5;

    localparam logic FMT_ARGB8888 = 1'b0;
    localparam logic FMT_ONE_BIT  = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
        logic       done;
    } pixel_t;

    typedef struct packed {
        logic busy;
        logic pix_valid;
    } unit_stat_t;

    // floor(x / 65535) for x below 256*65535: the shift estimate is low by at most one
    function automatic logic [7:0] div65535(input logic [23:0] x);
        logic [7:0]  q0;
        logic [16:0] t;
        begin
            q0 = x[23:16];
            t  = {1'b0, x[15:0]} + {9'd0, q0};
            div65535 = (t >= 17'd65535) ? q0 + 8'd1 : q0;
        end
    endfunction

    // floor(x / 255) for x below 256*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [7:0] q0;
        logic [8:0] t;
        begin
            q0 = x[15:8];
            t  = {1'b0, x[7:0]} + {1'b0, q0};
            div255 = (t >= 9'd255) ? q0 + 8'd1 : q0;
        end
    endfunction

endpackage

// ===== hdl/pbc_premul_unit.sv =====
// ----------------------------------------------------------------------------
// pbc_premul_unit
// Premultiplies one ARGB8888 pixel through a single shared 16x8 multiplier.
// ----------------------------------------------------------------------------
module pbc_premul_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [7:0]          src_red,
    input  logic [7:0]          src_green,
    input  logic [7:0]          src_blue,
    input  logic [7:0]          src_alpha,
    input  logic [7:0]          global_alpha,
    input  logic                end_flag,
    input  logic                take,
    output pbc_pkg::unit_stat_t stat,
    output pbc_pkg::pixel_t     pixel
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_AG   = 3'd1;
    localparam logic [2:0] ST_SAVE = 3'd2;
    localparam logic [2:0] ST_MR   = 3'd3;
    localparam logic [2:0] ST_MG   = 3'd4;
    localparam logic [2:0] ST_MB   = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  r_reg, g_reg, b_reg, a_reg, ga_reg;
    logic        end_reg;
    logic [15:0] ma_reg;
    logic [23:0] prod_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic [15:0] op_a;
    logic [7:0]  op_b;
    logic [23:0] mul_out;

    // shared multiplier operand select
    always_comb
    begin
        op_a = (state_reg == ST_AG) ? {8'd0, a_reg} : ma_reg;
        unique case (state_reg)
            ST_AG:   op_b = ga_reg;
            ST_MR:   op_b = r_reg;
            ST_MG:   op_b = g_reg;
            ST_MB:   op_b = b_reg;
            default: op_b = r_reg;
        endcase
    end

    assign mul_out = op_a * {8'd0, op_b};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_AG;
            ST_AG:   state_next = ST_SAVE;
            ST_SAVE: state_next = ST_MR;
            ST_MR:   state_next = ST_MG;
            ST_MG:   state_next = ST_MB;
            ST_MB:   state_next = ST_FIN;
            ST_FIN:  state_next = ST_DONE;
            ST_DONE: if (take) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            r_reg   <= src_red;
            g_reg   <= src_green;
            b_reg   <= src_blue;
            a_reg   <= src_alpha;
            ga_reg  <= global_alpha;
            end_reg <= end_flag;
        end
        if (state_reg == ST_AG || state_reg == ST_MR || state_reg == ST_MG ||
            state_reg == ST_MB)
        begin
            prod_reg <= mul_out;
        end
        if (state_reg == ST_SAVE)
        begin
            ma_reg    <= prod_reg[15:0];
            alpha_reg <= pbc_pkg::div255(prod_reg[15:0]);
        end
        if (state_reg == ST_MG)  red_reg   <= pbc_pkg::div65535(prod_reg);
        if (state_reg == ST_MB)  green_reg <= pbc_pkg::div65535(prod_reg);
        if (state_reg == ST_FIN) blue_reg  <= pbc_pkg::div65535(prod_reg);
    end

    assign stat.busy      = (state_reg != ST_IDLE);
    assign stat.pix_valid = (state_reg == ST_DONE);

    assign pixel.red   = red_reg;
    assign pixel.green = green_reg;
    assign pixel.blue  = blue_reg;
    assign pixel.alpha = alpha_reg;
    assign pixel.last  = 1'b1;
    assign pixel.done  = end_reg;

endmodule

// ===== hdl/pbc_bit_expander.sv =====
// ----------------------------------------------------------------------------
// pbc_bit_expander
// Walks one bitmap byte MSB first and hands out palette pixels one per cycle on take.
// ----------------------------------------------------------------------------
module pbc_bit_expander (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [7:0]          bitmap_byte,
    input  logic [3:0]          pix_count,
    input  logic                end_flag,
    input  logic [31:0]         fg_colour,
    input  logic [31:0]         bg_colour,
    input  logic                take,
    output pbc_pkg::unit_stat_t stat,
    output pbc_pkg::pixel_t     pixel
);

    logic        busy_reg, busy_next;
    logic [3:0]  idx_reg, idx_next;
    logic [3:0]  cnt_reg;
    logic [7:0]  bits_reg;
    logic        end_reg;
    logic        have_pix;
    logic        is_last;
    logic [2:0]  bit_sel;
    logic [31:0] colour;

    assign have_pix = busy_reg && (idx_reg < cnt_reg);
    assign is_last  = (idx_reg == cnt_reg - 4'd1);
    assign bit_sel  = 3'd7 - idx_reg[2:0];
    assign colour   = bits_reg[bit_sel] ? fg_colour : bg_colour;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                idx_next  = 4'd0;
            end
        end
        else if (idx_reg == cnt_reg)
        begin
            busy_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            bits_reg <= bitmap_byte;
            cnt_reg  <= pix_count;
            end_reg  <= end_flag;
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.pix_valid = have_pix;

    assign pixel.red   = colour[23:16];
    assign pixel.green = colour[15:8];
    assign pixel.blue  = colour[7:0];
    assign pixel.alpha = colour[31:24];
    assign pixel.last  = is_last;
    assign pixel.done  = is_last && end_reg;

endmodule

// ===== hdl/premultiply_blit_pixel_converter_core.sv =====
// ----------------------------------------------------------------------------
// premultiply_blit_pixel_converter_core
// Premultiplies ARGB8888 pixels or expands one-bit bytes to palette pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one source transaction: an
//   ARGB8888 pixel (source_format 0) or a bitmap byte (source_format 1).
//   Output channel (out_valid/out_ready) carries one pixel per transaction;
//   last_of_item flags the final pixel of an input, image_done the final
//   pixel of an image. The config channel (cfg_valid/cfg_ready) writes
//   registers by index and is always ready; write only while idle.
//   ARGB8888: a single 16x8 multiplier runs alpha*global_alpha and then the
//   three colour channels in turn (states AG, SAVE, MR, MG, MB, FIN); the
//   pixel then waits in DONE for the output register, and no new input is
//   taken until it has gone. One-bit: the byte expander emits up to eight
//   pixels, one per cycle unless stalled; a byte past draw_width emits none.
//   in_ready is low while either unit holds work. When the receiver stalls,
//   the output register holds its pixel and the active unit waits.
//   Reset clears control state, the byte column and the registers to their
//   defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module premultiply_blit_pixel_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  src_red,
    input  logic [7:0]  src_green,
    input  logic [7:0]  src_blue,
    input  logic [7:0]  src_alpha,
    input  logic [7:0]  bitmap_byte,
    input  logic        end_of_image,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    output logic        last_of_item,
    output logic        image_done
);

    // configuration registers
    logic        source_format_reg;
    logic [7:0]  global_alpha_reg;
    logic [31:0] fg_colour_reg;
    logic [31:0] bg_colour_reg;
    logic [12:0] draw_width_reg;
    logic [9:0]  row_bytes_reg;

    // row position state
    logic [8:0]  byte_column_reg, byte_column_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    pbc_pkg::pixel_t  out_pix_reg, out_pix_next;

    logic             in_accept;
    logic             start_premul, start_expand;
    logic             slot_free;
    logic             take_premul, take_expand;
    pbc_pkg::unit_stat_t prem_stat, exp_stat;
    pbc_pkg::pixel_t  prem_pix, exp_pix;

    logic [9:0]  rb_eff;
    logic [9:0]  col_inc;
    logic [12:0] base_col;
    logic [12:0] width_left;
    logic [3:0]  pix_count;

    assign cfg_ready    = 1'b1;
    assign in_ready     = !prem_stat.busy && !exp_stat.busy;
    assign in_accept    = in_valid && in_ready;
    assign start_premul = in_accept && (source_format_reg == pbc_pkg::FMT_ARGB8888);
    assign start_expand = in_accept && (source_format_reg == pbc_pkg::FMT_ONE_BIT);

    // the output register takes a new pixel when empty or being drained
    assign slot_free   = !out_valid_reg || out_ready;
    assign take_premul = slot_free && prem_stat.pix_valid;
    assign take_expand = slot_free && exp_stat.pix_valid;

    // clamp row length: zero acts as one, saturate at the maximum
    always_comb
    begin
        priority if (row_bytes_reg == 10'd0)
            rb_eff = 10'd1;
        else if (row_bytes_reg > 10'(pbc_pkg::MAX_ROW_BYTES))
            rb_eff = 10'(pbc_pkg::MAX_ROW_BYTES);
        else
            rb_eff = row_bytes_reg;
    end

    // pixels of this byte that fall below draw_width (a prefix of the byte)
    assign base_col   = {1'b0, byte_column_reg, 3'b000};
    assign width_left = draw_width_reg - base_col;
    always_comb
    begin
        priority if (draw_width_reg <= base_col)
            pix_count = 4'd0;
        else if (width_left >= 13'd8)
            pix_count = 4'd8;
        else
            pix_count = width_left[3:0];
    end

    // advance the byte column per bitmap byte, rewind at row and image end
    assign col_inc = {1'b0, byte_column_reg} + 10'd1;
    always_comb
    begin
        byte_column_next = byte_column_reg;
        if (start_expand)
        begin
            byte_column_next = (col_inc >= rb_eff) ? 9'd0 : col_inc[8:0];
        end
        if (in_accept && end_of_image)
        begin
            byte_column_next = 9'd0;
        end
    end

    // output register load and drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take_premul)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = prem_pix;
        end
        else if (take_expand)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = exp_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= pbc_pkg::FMT_ARGB8888;
            global_alpha_reg  <= 8'hFF;
            fg_colour_reg     <= 32'hFFFF_FFFF;
            bg_colour_reg     <= 32'h0000_0000;
            draw_width_reg    <= 13'd1;
            row_bytes_reg     <= 10'd1;
            byte_column_reg   <= 9'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pbc_pkg::REG_SOURCE_FORMAT: source_format_reg <= cfg_data[0];
                    pbc_pkg::REG_GLOBAL_ALPHA:  global_alpha_reg  <= cfg_data[7:0];
                    pbc_pkg::REG_FG_COLOUR:     fg_colour_reg     <= cfg_data;
                    pbc_pkg::REG_BG_COLOUR:     bg_colour_reg     <= cfg_data;
                    pbc_pkg::REG_DRAW_WIDTH:    draw_width_reg    <= cfg_data[12:0];
                    pbc_pkg::REG_ROW_BYTES:     row_bytes_reg     <= cfg_data[9:0];
                    default: ;
                endcase
            end
            byte_column_reg <= byte_column_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // pixel payload holds no reset
    always_ff @(posedge clk)
    begin
        out_pix_reg <= out_pix_next;
    end

    pbc_premul_unit u_premul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start_premul),
        .src_red      (src_red),
        .src_green    (src_green),
        .src_blue     (src_blue),
        .src_alpha    (src_alpha),
        .global_alpha (global_alpha_reg),
        .end_flag     (end_of_image),
        .take         (take_premul),
        .stat         (prem_stat),
        .pixel        (prem_pix)
    );

    pbc_bit_expander u_expand (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start_expand),
        .bitmap_byte (bitmap_byte),
        .pix_count   (pix_count),
        .end_flag    (end_of_image),
        .fg_colour   (fg_colour_reg),
        .bg_colour   (bg_colour_reg),
        .take        (take_expand),
        .stat        (exp_stat),
        .pixel       (exp_pix)
    );

    assign out_valid    = out_valid_reg;
    assign out_red      = out_pix_reg.red;
    assign out_green    = out_pix_reg.green;
    assign out_blue     = out_pix_reg.blue;
    assign out_alpha    = out_pix_reg.alpha;
    assign last_of_item = out_pix_reg.last;
    assign image_done   = out_pix_reg.done;

    `ASSERT_NEVER(a_units_exclusive, prem_stat.busy && exp_stat.busy, "both units busy")
    `ASSERT_PROP(a_busy_after_accept, in_accept |=> !in_ready, "ready right after accept")
    `ASSERT_PROP(a_done_is_last, (out_valid && image_done) |-> last_of_item, "done not last")

endmodule
